@@ sv/ucs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared constants, types and helpers for the URL component splitter.
// ----------------------------------------------------------------------------
package ucs_pkg;

    localparam int MAX_LEN_DEF = 4096;

    localparam int LEN_W = 13;
    localparam int OFS_W = 12;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_AT    = 8'h40;

    // progress through the "://" marker
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_COLON  = 2'd1;
    localparam logic [1:0] MARK_SLASH1 = 2'd2;

    // length of the "file://" prefix
    localparam logic [2:0] FILE_LEN = 3'd7;

    typedef struct packed {
        logic [LEN_W-1:0] protocol_len;
        logic             has_address;
        logic [LEN_W-1:0] path_start;
        logic             has_login;
        logic [OFS_W-1:0] at_offset;
        logic             has_password;
        logic [OFS_W-1:0] colon_offset;
        logic [LEN_W-1:0] total_len;
        logic             too_long;
    } t_result;

    function automatic logic [7:0] f_file_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h66; // f
            3'd1:    ch = 8'h69; // i
            3'd2:    ch = 8'h6C; // l
            3'd3:    ch = 8'h65; // e
            3'd4:    ch = CHAR_COLON;
            3'd5:    ch = CHAR_SLASH;
            3'd6:    ch = CHAR_SLASH;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ sv/ucs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_if
// Valid/ready channels: URL bytes in, split offsets out.
// ----------------------------------------------------------------------------
interface ucs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       byte_valid;
    logic       last;

    modport source (output valid, char_in, byte_valid, last, input ready);
    modport sink   (input valid, char_in, byte_valid, last, output ready);
endinterface

interface ucs_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] protocol_len;
    logic        has_address;
    logic [12:0] path_start;
    logic        has_login;
    logic [11:0] at_offset;
    logic        has_password;
    logic [11:0] colon_offset;
    logic [12:0] total_len;
    logic        too_long;

    modport source (
        output valid, protocol_len, has_address, path_start, has_login, at_offset,
               has_password, colon_offset, total_len, too_long,
        input  ready
    );
    modport sink (
        input  valid, protocol_len, has_address, path_start, has_login, at_offset,
               has_password, colon_offset, total_len, too_long,
        output ready
    );
endinterface

@@ sv/ucs_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_tracker
// Per-URL scan state: byte count, protocol marker, first slash, at and colon.
// ----------------------------------------------------------------------------
module ucs_tracker import ucs_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_byte_valid,
    input  logic       i_last,
    output t_result    o_result
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_count,  n_count;
    logic [1:0]    r_marker, n_marker;
    logic          r_proto,  n_proto;
    logic [CW-1:0] r_proto_len, n_proto_len;
    logic [2:0]    r_file_ok, n_file_ok;
    logic          r_slash,  n_slash;
    logic [CW-1:0] r_slash_pos, n_slash_pos;
    logic          r_at,     n_at;
    logic [CW-1:0] r_at_pos, n_at_pos;
    logic          r_colon,  n_colon;
    logic [CW-1:0] r_colon_pos, n_colon_pos;
    logic          r_ovf,    n_ovf;

    logic          is_file;
    logic          has_addr;
    logic          has_log;
    logic          has_pw;

    always_comb begin
        n_count     = r_count;
        n_marker    = r_marker;
        n_proto     = r_proto;
        n_proto_len = r_proto_len;
        n_file_ok   = r_file_ok;
        n_slash     = r_slash;
        n_slash_pos = r_slash_pos;
        n_at        = r_at;
        n_at_pos    = r_at_pos;
        n_colon     = r_colon;
        n_colon_pos = r_colon_pos;
        n_ovf       = r_ovf;

        if (i_byte_valid) begin
            if (r_count >= CW'(MAX_LEN)) begin
                n_ovf = 1'b1;
            end else begin
                if (CW'(r_file_ok) == r_count && r_count < CW'(FILE_LEN)
                        && i_char == f_file_char(r_file_ok)) begin
                    n_file_ok = r_file_ok + 3'd1;
                end
                if (!r_proto) begin
                    if (i_char == CHAR_COLON) begin
                        n_marker = MARK_COLON;
                    end else if (i_char == CHAR_SLASH && r_marker == MARK_COLON) begin
                        n_marker = MARK_SLASH1;
                    end else if (i_char == CHAR_SLASH && r_marker == MARK_SLASH1) begin
                        n_marker    = MARK_NONE;
                        n_proto     = 1'b1;
                        n_proto_len = CW'(r_count + 1'b1);
                    end else begin
                        n_marker = MARK_NONE;
                    end
                end else if (!r_slash) begin
                    if (i_char == CHAR_SLASH) begin
                        n_slash     = 1'b1;
                        n_slash_pos = r_count;
                    end else if (i_char == CHAR_AT && !r_at) begin
                        n_at     = 1'b1;
                        n_at_pos = r_count;
                    end else if (i_char == CHAR_COLON && !r_at && !r_colon) begin
                        n_colon     = 1'b1;
                        n_colon_pos = r_count;
                    end
                end
                n_count = CW'(r_count + 1'b1);
            end
        end
    end

    always_comb begin
        is_file  = (n_proto_len == CW'(FILE_LEN)) && (n_file_ok == FILE_LEN);
        has_addr = n_proto && !is_file && n_slash;
        has_log  = has_addr && n_at;
        has_pw   = has_log && n_colon;

        o_result.protocol_len = LEN_W'(n_proto_len);
        o_result.has_address  = has_addr;
        o_result.path_start   = has_addr ? LEN_W'(n_slash_pos) : LEN_W'(n_proto_len);
        o_result.has_login    = has_log;
        o_result.at_offset    = has_log ? OFS_W'(n_at_pos) : '0;
        o_result.has_password = has_pw;
        o_result.colon_offset = has_pw ? OFS_W'(n_colon_pos) : '0;
        o_result.total_len    = LEN_W'(n_count);
        o_result.too_long     = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_count     <= '0;
            r_marker    <= MARK_NONE;
            r_proto     <= 1'b0;
            r_proto_len <= '0;
            r_file_ok   <= '0;
            r_slash     <= 1'b0;
            r_slash_pos <= '0;
            r_at        <= 1'b0;
            r_at_pos    <= '0;
            r_colon     <= 1'b0;
            r_colon_pos <= '0;
            r_ovf       <= 1'b0;
        end else if (i_take) begin
            r_count     <= n_count;
            r_marker    <= n_marker;
            r_proto     <= n_proto;
            r_proto_len <= n_proto_len;
            r_file_ok   <= n_file_ok;
            r_slash     <= n_slash;
            r_slash_pos <= n_slash_pos;
            r_at        <= n_at;
            r_at_pos    <= n_at_pos;
            r_colon     <= n_colon;
            r_colon_pos <= n_colon_pos;
            r_ovf       <= n_ovf;
        end
    end

endmodule

@@ sv/ucs_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module ucs_out_reg import ucs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    ucs_out_if.source  o_out
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.protocol_len = r_result.protocol_len;
    assign o_out.has_address  = r_result.has_address;
    assign o_out.path_start   = r_result.path_start;
    assign o_out.has_login    = r_result.has_login;
    assign o_out.at_offset    = r_result.at_offset;
    assign o_out.has_password = r_result.has_password;
    assign o_out.colon_offset = r_result.colon_offset;
    assign o_out.total_len    = r_result.total_len;
    assign o_out.too_long     = r_result.too_long;

endmodule

@@ sv/url_component_splitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_component_splitter
// Splits a byte-serial URL into protocol, login, password, host and path.
//
// Input channel i_in carries one URL byte per transfer; byte_valid = 0 marks
// a transfer without a byte (empty URL), last = 1 closes the URL.
// Output channel o_out carries one result per URL: the offsets of the
// protocol end, path start, first '@' and first ':' before it plus length and overflow.
// One byte is taken per cycle while i_in.ready is high; the scan state sits
// in one register bank updated by byte compares, so one transfer per cycle.
// The result is registered and shown on o_out in the cycle after the last transfer.
// A held result keeps i_in open only if o_out.ready is high in that cycle:
// a stalled receiver stalls the input after one result is waiting.
// Bytes past MAX_LEN are dropped and set too_long.
// Reset clears the scan state and empties the result register.
// ----------------------------------------------------------------------------
module url_component_splitter import ucs_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ucs_in_if.sink    i_in,
    ucs_out_if.source o_out
);

    t_result result;
    logic    take;

    assign i_in.ready = !o_out.valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    ucs_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_char       (i_in.char_in),
        .i_byte_valid (i_in.byte_valid),
        .i_last       (i_in.last),
        .o_result     (result)
    );

    ucs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && i_in.last),
        .i_result (result),
        .o_out    (o_out)
    );

endmodule
